// ----- rtl/mmm_pkg.sv -----
package mmm_pkg;

   // Field widths
   localparam int RANK_W   = 3;
   localparam int TYPE_W   = 8;
   localparam int COMM_W   = 8;
   localparam int TAG_W    = 16;
   localparam int COUNT_W  = 16;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;

   // Default number of ranks in the mailbox matrix
   localparam int NUM_RANKS_DEF = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int RANKS_CFG_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_RANKS_IN_USE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USER_TAG_MASK = 1'd1;

   localparam logic [RANKS_CFG_W-1:0] RANKS_RESET = 4'd8;
   localparam logic [TAG_W-1:0]       MASK_RESET  = 16'hFFFF;

   // Request kinds
   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_RECV = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PENDING = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TYPE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TAG     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_COMM    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd6;

   // One mailbox slot as kept in the slot memory
   typedef struct packed {
      logic [TYPE_W-1:0]  data_type;
      logic [COMM_W-1:0]  comm_id;
      logic [TAG_W-1:0]   msg_tag;
      logic [COUNT_W-1:0] msg_count;
      logic [ADDR_W-1:0]  data_address;
   } slot_entry_type;

endpackage

// ----- rtl/mmm_req_if.sv -----
interface mmm_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [mmm_pkg::RANK_W-1:0]     self_rank;
   logic [mmm_pkg::RANK_W-1:0]     peer_rank;
   logic                           any_source;
   logic                           any_tag;
   logic [mmm_pkg::TYPE_W-1:0]     data_type;
   logic [mmm_pkg::COMM_W-1:0]     comm_id;
   logic [mmm_pkg::TAG_W-1:0]      msg_tag;
   logic [mmm_pkg::COUNT_W-1:0]    msg_count;
   logic [mmm_pkg::ADDR_W-1:0]     data_address;

   modport source (
      output valid, kind, self_rank, peer_rank, any_source, any_tag,
             data_type, comm_id, msg_tag, msg_count, data_address,
      input  ready
   );

   modport sink (
      input  valid, kind, self_rank, peer_rank, any_source, any_tag,
             data_type, comm_id, msg_tag, msg_count, data_address,
      output ready
   );
endinterface

// ----- rtl/mmm_rsp_if.sv -----
interface mmm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mmm_pkg::STATUS_W-1:0]   status;
   logic [mmm_pkg::RANK_W-1:0]     matched_source;
   logic [mmm_pkg::TAG_W-1:0]      matched_tag;
   logic [mmm_pkg::ADDR_W-1:0]     matched_address;

   modport source (
      output valid, status, matched_source, matched_tag, matched_address,
      input  ready
   );

   modport sink (
      input  valid, status, matched_source, matched_tag, matched_address,
      output ready
   );
endinterface

// ----- rtl/mailbox_matrix_message_matcher_top.sv -----
// Mailbox matrix message matcher. One message slot is kept per (source,
// destination) rank pair; slot payloads live in a single-port synchronous
// memory with a registered read, and the full flags in flip-flops that
// reset clears at once, so no clearing pass is needed. Transactions are
// handled one at a time by a small sequencer. After acceptance a send passes
// through S_ISSUE and S_RESULT. A named-source receive passes through S_ISSUE,
// S_CHECK and S_RESULT, skipping S_CHECK when its slot is empty or a rank is
// out of range. An any-source receive walks sources 0 upward, below the limit
// min(ranks_in_use, NUM_RANKS): an empty slot takes only a pass through
// S_ISSUE, a full slot a memory read in S_ISSUE and a compare in S_CHECK.
// The result shows on rsp_bus in the cycle the next request can be
// accepted. The result register lets the next request in while a result still
// waits on rsp_bus; the sequencer stalls only when a second result is ready to
// leave before the first one has been taken.
// Configuration writes are taken at any time but belong to idle periods.
module mailbox_matrix_message_matcher_top #(
   parameter int NUM_RANKS = mmm_pkg::NUM_RANKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mmm_req_if.sink                             req_bus,
   mmm_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [mmm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mmm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Only ranks that fit the 3-bit rank fields can ever own a slot
   localparam int MAX_FIELD_RANKS = 1 << mmm_pkg::RANK_W;
   localparam int USED_RANKS = (NUM_RANKS < MAX_FIELD_RANKS) ? NUM_RANKS : MAX_FIELD_RANKS;
   localparam int DEPTH      = USED_RANKS * USED_RANKS;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int SRC_W      = mmm_pkg::RANKS_CFG_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_CHECK,
      S_RESULT
   } state_type;

   // Sequencer and configuration registers
   state_type                          state_ff, state_in;
   logic [SRC_W-1:0]                   src_ff, src_in;
   logic [DEPTH-1:0]                   slot_full_ff, slot_full_in;
   logic [mmm_pkg::RANKS_CFG_W-1:0]    ranks_ff, ranks_in;
   logic [mmm_pkg::TAG_W-1:0]          mask_ff, mask_in;

   // Latched request
   logic                               kind_ff, kind_in;
   logic [mmm_pkg::RANK_W-1:0]         self_ff, self_in;
   logic [mmm_pkg::RANK_W-1:0]         peer_ff, peer_in;
   logic                               any_src_ff, any_src_in;
   logic                               any_tag_ff, any_tag_in;
   mmm_pkg::slot_entry_type            req_ff, req_in;

   // Pending result and output register
   logic [mmm_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [mmm_pkg::RANK_W-1:0]         res_src_ff, res_src_in;
   logic [mmm_pkg::TAG_W-1:0]          res_tag_ff, res_tag_in;
   logic [mmm_pkg::ADDR_W-1:0]         res_addr_ff, res_addr_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mmm_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [mmm_pkg::RANK_W-1:0]         rsp_src_ff, rsp_src_in;
   logic [mmm_pkg::TAG_W-1:0]          rsp_tag_ff, rsp_tag_in;
   logic [mmm_pkg::ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;

   // Slot memory
   mmm_pkg::slot_entry_type            slot_mem [DEPTH];
   mmm_pkg::slot_entry_type            rd_data_ff;
   logic                               mem_we;

   // Slot addressing
   logic [SRC_W-1:0]                   row;
   logic [mmm_pkg::RANK_W-1:0]         col;
   logic                               row_ok;
   logic                               col_ok;
   logic [IDX_W-1:0]                   idx;
   logic [SRC_W-1:0]                   scan_limit;
   logic                               req_fire;
   logic                               type_eq;
   logic                               tag_ok;
   logic                               comm_eq;
   logic                               count_eq;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // Send addresses (self, peer); receive addresses (source, self)
   assign row    = (kind_ff == mmm_pkg::KIND_SEND) ? SRC_W'(self_ff) : src_ff;
   assign col    = (kind_ff == mmm_pkg::KIND_SEND) ? peer_ff : self_ff;
   assign row_ok = 32'(row) < USED_RANKS;
   assign col_ok = 32'(col) < USED_RANKS;
   assign idx    = IDX_W'(32'(row) * USED_RANKS + 32'(col));

   assign scan_limit = (32'(ranks_ff) > NUM_RANKS) ? SRC_W'(NUM_RANKS) : ranks_ff;

   // Slot compare against the latched request
   assign type_eq  = rd_data_ff.data_type == req_ff.data_type;
   assign tag_ok   = any_tag_ff ? ((rd_data_ff.msg_tag & mask_ff) != '0)
                                : (rd_data_ff.msg_tag == req_ff.msg_tag);
   assign comm_eq  = rd_data_ff.comm_id == req_ff.comm_id;
   assign count_eq = rd_data_ff.msg_count == req_ff.msg_count;

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      slot_full_in  = slot_full_ff;
      ranks_in      = ranks_ff;
      mask_in       = mask_ff;
      kind_in       = kind_ff;
      self_in       = self_ff;
      peer_in       = peer_ff;
      any_src_in    = any_src_ff;
      any_tag_in    = any_tag_ff;
      req_in        = req_ff;
      res_status_in = res_status_ff;
      res_src_in    = res_src_ff;
      res_tag_in    = res_tag_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_addr_in   = rsp_addr_ff;
      mem_we        = 1'b0;

      // Configuration writes
      if (csr_we) begin
         case (csr_index)
            mmm_pkg::CSR_RANKS_IN_USE:  ranks_in = csr_wdata[mmm_pkg::RANKS_CFG_W-1:0];
            mmm_pkg::CSR_USER_TAG_MASK: mask_in  = csr_wdata[mmm_pkg::TAG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in             = req_bus.kind;
               self_in             = req_bus.self_rank;
               peer_in             = req_bus.peer_rank;
               any_src_in          = req_bus.any_source;
               any_tag_in          = req_bus.any_tag;
               req_in.data_type    = req_bus.data_type;
               req_in.comm_id      = req_bus.comm_id;
               req_in.msg_tag      = req_bus.msg_tag;
               req_in.msg_count    = req_bus.msg_count;
               req_in.data_address = req_bus.data_address;
               src_in   = req_bus.any_source ? '0 : SRC_W'(req_bus.peer_rank);
               state_in = S_ISSUE;
            end
         end

         S_ISSUE: begin
            res_status_in = mmm_pkg::ST_PENDING;
            res_src_in    = '0;
            res_tag_in    = '0;
            res_addr_in   = '0;
            if (kind_ff == mmm_pkg::KIND_SEND) begin
               state_in = S_RESULT;
               if (!row_ok || !col_ok || slot_full_ff[idx]) begin
                  res_status_in = mmm_pkg::ST_BUSY;
               end else begin
                  mem_we            = 1'b1;
                  slot_full_in[idx] = 1'b1;
                  res_status_in     = mmm_pkg::ST_OK;
               end
            end else if (!col_ok) begin
               state_in = S_RESULT;
            end else if (any_src_ff && (src_ff >= scan_limit)) begin
               // scan exhausted
               state_in = S_RESULT;
            end else if (!row_ok || !slot_full_ff[idx]) begin
               if (any_src_ff) src_in = src_ff + SRC_W'(1);
               else            state_in = S_RESULT;
            end else begin
               // slot full: read issued this cycle
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            res_status_in = mmm_pkg::ST_PENDING;
            res_src_in    = '0;
            res_tag_in    = '0;
            res_addr_in   = '0;
            if (any_src_ff) begin
               if (type_eq && tag_ok && count_eq) begin
                  slot_full_in[idx] = 1'b0;
                  res_status_in     = mmm_pkg::ST_OK;
                  res_src_in        = row[mmm_pkg::RANK_W-1:0];
                  res_tag_in        = rd_data_ff.msg_tag;
                  res_addr_in       = rd_data_ff.data_address;
                  state_in          = S_RESULT;
               end else begin
                  src_in   = src_ff + SRC_W'(1);
                  state_in = S_ISSUE;
               end
            end else begin
               state_in = S_RESULT;
               if (!type_eq)        res_status_in = mmm_pkg::ST_TYPE;
               else if (!tag_ok)    res_status_in = mmm_pkg::ST_TAG;
               else if (!comm_eq)   res_status_in = mmm_pkg::ST_COMM;
               else if (!count_eq)  res_status_in = mmm_pkg::ST_COUNT;
               else begin
                  slot_full_in[idx] = 1'b0;
                  res_status_in     = mmm_pkg::ST_OK;
                  res_src_in        = row[mmm_pkg::RANK_W-1:0];
                  res_tag_in        = rd_data_ff.msg_tag;
                  res_addr_in       = rd_data_ff.data_address;
               end
            end
         end

         S_RESULT: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_src_in    = res_src_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State, configuration and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_full_ff <= '0;
         ranks_ff     <= mmm_pkg::RANKS_RESET;
         mask_ff      <= mmm_pkg::MASK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_full_ff <= slot_full_in;
         ranks_ff     <= ranks_in;
         mask_ff      <= mask_in;
      end
      src_ff        <= src_in;
      kind_ff       <= kind_in;
      self_ff       <= self_in;
      peer_ff       <= peer_in;
      any_src_ff    <= any_src_in;
      any_tag_ff    <= any_tag_in;
      req_ff        <= req_in;
      res_status_ff <= res_status_in;
      res_src_ff    <= res_src_in;
      res_tag_ff    <= res_tag_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // Slot memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[idx] <= req_ff;
      rd_data_ff <= slot_mem[idx];
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.matched_source  = rsp_src_ff;
   assign rsp_bus.matched_tag     = rsp_tag_ff;
   assign rsp_bus.matched_address = rsp_addr_ff;

`ifndef SYNTHESIS
   // compare only on data read in the cycle before
   a_check_after_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_ISSUE))
      else $error("slot compare without a preceding memory read");

   // a posted send marks its slot full
   a_send_sets_full: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> slot_full_ff[$past(idx)])
      else $error("send did not mark its slot full");

   // the any-source scan never runs past its limit
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_ISSUE) && (kind_ff == mmm_pkg::KIND_RECV) && any_src_ff)
      |-> (src_ff <= scan_limit))
      else $error("any-source scan past its limit");

   // a consumed message empties its slot
   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CHECK) && (res_status_in == mmm_pkg::ST_OK))
      |=> !slot_full_ff[$past(idx)])
      else $error("matched slot left full");
`endif

endmodule
